FILE: design/wrmh_pkg.sv
// wrmh_pkg: shared constants, controller state type and the command/status
// structs that join the word_rotate_multiply_hash controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wrmh_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned RemW = 2;
  localparam int unsigned IdxW = 2;

  localparam logic [WordW-1:0] HashPrime = 32'd2654435761;
  localparam int unsigned RotL = 13;
  localparam int unsigned RotR = 19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // input beat taken, latch item and start hash
    logic mul;    // register operand * prime
    logic add;    // hash = rotl(hash + product), advance byte
    logic emit;   // move hash into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rem_zero;  // no mixes left for this item
    logic last;      // latched last flag
    logic out_free;  // output register can take a new beat
  } sts_t;

endpackage

`default_nettype wire

FILE: design/word_rotate_multiply_hash.sv
// word_rotate_multiply_hash: top level of the streaming multiply-rotate hash.
// Depends on wrmh_pkg, wrmh_ctrl and wrmh_dp.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one beat per message word:
//    data_word_i (little-endian bytes), byte_count_i (0..4, 5..7 act as 4)
//    and last_i. Output channel (out_valid_o/out_ready_i) carries one beat,
//    hash_value_o, per message, on its last item.
//  - Each mix goes through one shared 32x32 multiplier: a multiply cycle
//    registers operand * prime, an add cycle adds and rotates left by 13.
//  - Per item: the idle step takes it, then each mix runs a multiply and an
//    add step (mixes = 1 for a full word, else byte_count), and a closing
//    check in the multiply state ends the mixes. A last item then moves the
//    hash into the output register in the emit step.
//  - in_ready_o is high only while the sequencer is idle; the next item is
//    taken while a finished hash still waits in the output register.
//  - Receiver stall: a new last item finishes its mixes and then waits in
//    the emit step until the output register frees up.
//  - cfg_we_i/cfg_wdata_i write the seed; it applies from the next message.
//    Reset clears the seed, the message state and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module word_rotate_multiply_hash (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // seed register write
  input  wire logic                        cfg_we_i,
  input  wire logic [wrmh_pkg::WordW-1:0]  cfg_wdata_i,
  // input beats
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [wrmh_pkg::WordW-1:0]  data_word_i,
  input  wire logic [wrmh_pkg::CountW-1:0] byte_count_i,
  input  wire logic                        last_i,
  // result beats
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [wrmh_pkg::WordW-1:0]       hash_value_o
);

  wrmh_pkg::cmd_t cmd;
  wrmh_pkg::sts_t sts;

  // sequencer: idle -> (multiply -> add-rotate)* -> emit on a last item, else back to idle
  wrmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // seed, running hash, shared multiplier and output register
  wrmh_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .hash_value_o (hash_value_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

`default_nettype wire

FILE: design/wrmh_ctrl.sv
// wrmh_ctrl: sequencer for the multiply-rotate hash.
// Depends on wrmh_pkg (state_e, cmd_t, sts_t).
`timescale 1ns / 1ps
`default_nettype none

module wrmh_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire wrmh_pkg::sts_t sts_i,
  output wrmh_pkg::cmd_t     cmd_o
);

  wrmh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrmh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wrmh_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = wrmh_pkg::ST_MUL;
      end
      wrmh_pkg::ST_MUL: begin
        if (!sts_i.rem_zero) begin
          state_d = wrmh_pkg::ST_ADD;
        end else if (sts_i.last) begin
          state_d = wrmh_pkg::ST_EMIT;
        end else begin
          state_d = wrmh_pkg::ST_IDLE;
        end
      end
      wrmh_pkg::ST_ADD: begin
        state_d = wrmh_pkg::ST_MUL;
      end
      wrmh_pkg::ST_EMIT: begin
        if (sts_i.out_free) state_d = wrmh_pkg::ST_IDLE;
      end
      default: begin
        state_d = wrmh_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      wrmh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      wrmh_pkg::ST_MUL: begin
        cmd_o.mul = !sts_i.rem_zero;
      end
      wrmh_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
      end
      wrmh_pkg::ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/wrmh_dp.sv
// wrmh_dp: hash datapath - seed register, item latch, shared multiplier,
// add-rotate stage and output register.
// Depends on wrmh_pkg (constants, cmd_t, sts_t).
`timescale 1ns / 1ps
`default_nettype none

module wrmh_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [wrmh_pkg::WordW-1:0]      cfg_wdata_i,
  input  wire logic [wrmh_pkg::WordW-1:0]      data_word_i,
  input  wire logic [wrmh_pkg::CountW-1:0]     byte_count_i,
  input  wire logic                            last_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic [wrmh_pkg::WordW-1:0]           hash_value_o,
  input  wire wrmh_pkg::cmd_t                  cmd_i,
  output wrmh_pkg::sts_t                       sts_o
);

  logic [wrmh_pkg::WordW-1:0]  seed_q;
  logic [wrmh_pkg::WordW-1:0]  hash_q, hash_d;
  logic [wrmh_pkg::WordW-1:0]  word_q;
  logic [wrmh_pkg::WordW-1:0]  prod_q;
  logic [wrmh_pkg::WordW-1:0]  out_q;
  logic [wrmh_pkg::RemW-1:0]   rem_q;
  logic [wrmh_pkg::IdxW-1:0]   idx_q;
  logic                        full_q;
  logic                        last_q;
  logic                        in_msg_q;
  logic                        out_valid_q;

  logic [wrmh_pkg::WordW-1:0]  start_hash;
  logic [wrmh_pkg::WordW-1:0]  shifted;
  logic [wrmh_pkg::WordW-1:0]  byte_sext;
  logic [wrmh_pkg::WordW-1:0]  operand;
  logic [wrmh_pkg::WordW-1:0]  sum;
  logic                        full_in;

  assign start_hash = in_msg_q ? hash_q : seed_q + wrmh_pkg::HashPrime;
  assign full_in    = byte_count_i[wrmh_pkg::CountW-1];  // 4..7 is a full word

  assign shifted   = word_q >> {idx_q, 3'b000};
  assign byte_sext = {{(wrmh_pkg::WordW-8){shifted[7]}}, shifted[7:0]};
  assign operand   = full_q ? word_q : byte_sext;

  assign sum    = hash_q + prod_q;
  assign hash_d = (sum << wrmh_pkg::RotL) | (sum >> wrmh_pkg::RotR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      full_q      <= 1'b0;
      last_q      <= 1'b0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) seed_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        full_q   <= full_in;
        last_q   <= last_i;
        in_msg_q <= !last_i;
        idx_q    <= '0;
        rem_q    <= full_in ? wrmh_pkg::RemW'(1) : byte_count_i[wrmh_pkg::RemW-1:0];
      end else if (cmd_i.add) begin
        rem_q <= rem_q - wrmh_pkg::RemW'(1);
        idx_q <= idx_q + wrmh_pkg::IdxW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= data_word_i;
      hash_q <= start_hash;
    end else if (cmd_i.add) begin
      hash_q <= hash_d;
    end
    if (cmd_i.mul) prod_q <= operand * wrmh_pkg::HashPrime;
    if (cmd_i.emit) out_q <= hash_q;
  end

  assign out_valid_o     = out_valid_q;
  assign hash_value_o    = out_q;
  assign sts_o.rem_zero  = (rem_q == '0);
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

`ifndef SYNTH
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_i.load, cmd_i.mul, cmd_i.add, cmd_i.emit}) <= 1)
    else $error("wrmh_dp: more than one command in a cycle");

  a_add_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add |=> rem_q == $past(rem_q) - wrmh_pkg::RemW'(1))
    else $error("wrmh_dp: remaining mix count did not step down");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (rem_q == '0) && last_q)
    else $error("wrmh_dp: emit before the last item finished");

  a_mul_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> rem_q != '0)
    else $error("wrmh_dp: multiply with no mixes left");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench: self-checking bench for word_rotate_multiply_hash.
// It uses word_rotate_multiply_hash and the widths from wrmh_pkg. A
// beat-level predictor checks each hash_value beat, in order.
`timescale 1ns / 1ps

module testbench;

  import wrmh_pkg::*;

  localparam logic [WordW-1:0] GOLDEN_PRIME = 32'h9E37_79B1;  // 2654435761
  localparam int unsigned SETTLE_CYCLES = 16;   // longer than the worst item occupancy
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_ITEMS = 130;     // per random phase
  localparam int unsigned NUM_PHASES = 3;
  localparam int unsigned NUM_ROWS = 18;

  // One directed beat. When has_hash is set, the hash is known by inspection
  // and is used as the expectation in place of the predictor's value.
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    logic              last;
    logic              has_hash;
    logic [WordW-1:0]  hash;
  } vec_row_t;

  localparam vec_row_t DIR_ROWS [NUM_ROWS] = '{
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, GOLDEN_PRIME},  // empty message, seed 0
    '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h0},
    '{32'h1234_5678, 3'd5, 1'b0, 1'b0, 32'h0},         // oversized counts
    '{32'h89AB_CDEF, 3'd6, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, 32'h0},
    '{32'hDEAD_BE80, 3'd1, 1'b1, 1'b0, 32'h0},         // junk above count, neg byte
    '{32'hAAAA_7F80, 3'd2, 1'b0, 1'b0, 32'h0},         // short beat mid-message
    '{32'h55FF_FF7F, 3'd3, 1'b0, 1'b0, 32'h0},
    '{32'hCAFE_F00D, 3'd4, 1'b1, 1'b0, 32'h0},
    '{32'hFFFF_FF7F, 3'd1, 1'b1, 1'b0, 32'h0},
    '{32'h0000_00FF, 3'd3, 1'b1, 1'b0, 32'h0},
    '{32'h8080_8080, 3'd3, 1'b0, 1'b0, 32'h0},
    '{32'h8080_8080, 3'd4, 1'b1, 1'b0, 32'h0},
    '{32'h7654_3210, 3'd0, 1'b0, 1'b0, 32'h0},         // zero-byte message over
    '{32'hFEDC_BA98, 3'd0, 1'b1, 1'b1, GOLDEN_PRIME},  //   two beats
    '{32'h0000_0000, 3'd1, 1'b1, 1'b0, 32'h0},
    '{32'h7F7F_7F7F, 3'd2, 1'b1, 1'b0, 32'h0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [WordW-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [WordW-1:0]  data_word_i = '0;
  logic [CountW-1:0] byte_count_i = '0;
  logic              last_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WordW-1:0]  hash_value_o;

  // Typed expectation riding along with the beat on the input channel.
  logic              row_has_hash = 1'b0;
  logic [WordW-1:0]  row_hash = '0;

  // Idle odds in percent, changed per phase by the stimulus process.
  int unsigned       send_idle_pct = 25;
  int unsigned       recv_idle_pct = 51;

  // Predictor state: seed register, running hash, open-message flag.
  logic [WordW-1:0]  seed_q = '0;
  logic [WordW-1:0]  run_hash_q = GOLDEN_PRIME;
  logic              msg_open_q = 1'b0;

  logic [WordW-1:0]  hash_q [$];   // hashes still owed by the block
  int unsigned       error_cnt = 0;
  int unsigned       cycle_cnt = 0;

  word_rotate_multiply_hash uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  always #1 clk_i = ~clk_i;

  // One mix: add v * prime, then rotate left by 13.
  function automatic logic [WordW-1:0] mix_rotl(logic [WordW-1:0] h, logic [WordW-1:0] v);
    logic [WordW-1:0] sum;
    sum = h + v * GOLDEN_PRIME;
    return {sum[18:0], sum[31:19]};
  endfunction

  // Fold one beat into the hash: a full word (count 4..7) is one mix, a short
  // beat mixes each valid byte, low byte first, sign-extended.
  function automatic logic [WordW-1:0] fold_beat(logic [WordW-1:0] h,
                                                 logic [WordW-1:0] word,
                                                 logic [CountW-1:0] count);
    logic [WordW-1:0] b;
    int i;
    if (count >= 3'd4) begin
      return mix_rotl(h, word);
    end
    for (i = 0; i < int'(count); i++) begin
      b = {{24{word[8*i+7]}}, word[8*i +: 8]};
      h = mix_rotl(h, b);
    end
    return h;
  endfunction

  // Everything is sampled at the rising edge, before the block's own
  // register updates land, so the values seen are the pre-edge ones.
  always @(posedge clk_i) begin : scoreboard_b
    logic [WordW-1:0] h;
    logic [WordW-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        h = fold_beat(msg_open_q ? run_hash_q : seed_q + GOLDEN_PRIME,
                      data_word_i, byte_count_i);
        if (last_i) begin
          hash_q.push_back(row_has_hash ? row_hash : h);
          msg_open_q = 1'b0;
        end else begin
          run_hash_q = h;
          msg_open_q = 1'b1;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (hash_q.size() == 0) begin
          $error("hash_value: no beat expected, got %h", hash_value_o);
          error_cnt++;
        end else begin
          want = hash_q.pop_front();
          if (hash_value_o !== want) begin
            $error("hash_value: expected %h, got %h", want, hash_value_o);
            error_cnt++;
          end
        end
      end
      // The seed only matters for the next message, so it is taken last.
      if (cfg_we_i) begin
        seed_q = cfg_wdata_i;
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drive one input beat. Called and returns at a falling edge; valid stays
  // high into the next call so back-to-back beats need no gap.
  task automatic send_beat(input logic [WordW-1:0] word, input logic [CountW-1:0] count,
                           input logic last, input logic has_hash,
                           input logic [WordW-1:0] hash);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    data_word_i  = word;
    byte_count_i = count;
    last_i       = last;
    row_has_hash = has_hash;
    row_hash     = hash;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold the sender until every owed hash has come back.
  task automatic wait_empty();
    in_valid_i = 1'b0;
    while (hash_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // A non-last beat leaves no trace in the queue, so give the block time
  // to finish its mixes before the seed moves.
  task automatic write_seed(input logic [WordW-1:0] value);
    wait_empty();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Random beat: mostly full words, some short beats, a few oversized
  // counts; roughly one beat in four closes the message.
  task automatic send_random(input int force_last);
    logic [CountW-1:0] count;
    logic              last;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      count = 3'd4;
    end else if (pick < 90) begin
      count = CountW'($urandom_range(3));
    end else begin
      count = CountW'($urandom_range(7, 5));
    end
    last = ($urandom_range(3) == 0);
    if (force_last >= 0) begin
      last = force_last[0];
    end
    send_beat($urandom, count, last, 1'b0, '0);
  endtask

  initial begin : stimulus_b
    logic [WordW-1:0] phase_seed [NUM_PHASES];
    int unsigned      phase_send [NUM_PHASES];
    int unsigned      phase_recv [NUM_PHASES];
    int               p;
    int               n;

    phase_seed = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000};
    phase_send = '{25, 51, 0};
    phase_recv = '{51, 25, 0};

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats run on the reset seed with the first idle mix.
    send_idle_pct = 25;
    recv_idle_pct = 51;
    for (n = 0; n < NUM_ROWS; n++) begin
      send_beat(DIR_ROWS[n].word, DIR_ROWS[n].count, DIR_ROWS[n].last,
                DIR_ROWS[n].has_hash, DIR_ROWS[n].hash);
    end

    // Random phases. The first two end on a non-last beat, so the seed
    // write below lands while a message is open and must not disturb it.
    for (p = 0; p < NUM_PHASES; p++) begin
      write_seed(phase_seed[p]);
      send_idle_pct = phase_send[p];
      recv_idle_pct = phase_recv[p];
      for (n = 0; n < RAND_ITEMS; n++) begin
        if (n == RAND_ITEMS - 1) begin
          send_random(p == NUM_PHASES - 1 ? 1 : 0);
        end else begin
          send_random(-1);
        end
        // Now and then let the pipeline run dry before the next beat.
        if ($urandom_range(39) == 0) begin
          wait_empty();
        end
      end
    end

    wait_empty();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
